FILE: sv/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg: shared types, constants and tables of the morse code keyer
// Holds the character code table, the unit space table, register indexes and
// the entry type that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package mck_pkg;

  // field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned WpmW   = 6;
  localparam int unsigned WeightW = 7;
  localparam int unsigned SpaceW = 8;
  localparam int unsigned DurW   = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxWpm    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxWeight = 2'd1;

  // register reset values
  localparam logic [WpmW-1:0]    WpmReset    = 6'd20;
  localparam logic [WeightW-1:0] WeightReset = 7'd48;

  // characters and table range
  localparam logic [CharW-1:0] CharSpace = 8'd32;
  localparam logic [CharW-1:0] CharFirst = 8'd33;
  localparam logic [CharW-1:0] CharLast  = 8'd126;
  localparam logic [CharW-1:0] CodeEmpty = 8'h01;

  // weight below this is raised to it; the divisor is weight minus sixteen
  localparam logic [WeightW-1:0] WeightMin  = 7'd17;
  localparam logic [WeightW-1:0] WeightBias = 7'd16;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DivSteps = DurW;
  localparam int unsigned DivCntW  = 4;

  localparam logic [DurW-1:0] DurMax = 13'h1FFF;

  // reverse-binary codes for ASCII 33..126, leading 1 marks the end
  localparam logic [7:0] CodeTable [94] = '{
    8'h75, 8'h52, 8'h01, 8'hC8, 8'h68, 8'h1A, 8'h5E, 8'h2D, 8'h6D, 8'h01,
    8'h2D, 8'h73, 8'h31, 8'h2A, 8'h29, 8'h3F, 8'h3E, 8'h3C, 8'h38, 8'h30,
    8'h20, 8'h21, 8'h23, 8'h27, 8'h2F, 8'h47, 8'h55, 8'h22, 8'h31, 8'h2A,
    8'h4C, 8'h56, 8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B, 8'h10,
    8'h04, 8'h1E, 8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B, 8'h0A,
    8'h08, 8'h03, 8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13, 8'h01, 8'h40,
    8'h01, 8'h01, 8'h6C, 8'h5E, 8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14,
    8'h0B, 8'h10, 8'h04, 8'h1E, 8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16,
    8'h1B, 8'h0A, 8'h08, 8'h03, 8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13,
    8'h70, 8'h01, 8'h28, 8'h01
  };

  // unit space in ms, 1200 / wpm truncated; speeds below 5 count as 5
  localparam logic [SpaceW-1:0] SpaceTable [64] = '{
    8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd200, 8'd171,
    8'd150, 8'd133, 8'd120, 8'd109, 8'd100, 8'd92,  8'd85,  8'd80,
    8'd75,  8'd70,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,  8'd52,
    8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd40,  8'd38,
    8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,
    8'd30,  8'd29,  8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd25,
    8'd25,  8'd24,  8'd24,  8'd23,  8'd23,  8'd22,  8'd22,  8'd21,
    8'd21,  8'd21,  8'd20,  8'd20,  8'd20,  8'd19,  8'd19,  8'd19
  };

  // one classified character, ready for the back part
  typedef struct packed {
    logic [7:0]        code;
    logic [SpaceW-1:0] space;
    logic [DurW-1:0]   dit;
    logic [DurW-1:0]   dash;
    logic              is_space;
    logic              prev_space;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/mck_if.sv
// ----------------------------------------------------------------------------
// mck_if: channel interfaces of the morse code keyer
// Character input, segment output and configuration write channels, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------
interface mck_char_if;
  logic                       valid;
  logic                       ready;
  logic [mck_pkg::CharW-1:0]  character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface mck_seg_if;
  logic                      valid;
  logic                      ready;
  logic                      key_down;
  logic [mck_pkg::DurW-1:0]  duration_ms;
  logic                      last_segment;

  modport source (output valid, output key_down, output duration_ms,
                  output last_segment, input ready);
  modport sink   (input valid, input key_down, input duration_ms,
                  input last_segment, output ready);
endinterface

interface mck_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mck_pkg::CfgIdxW-1:0]   reg_index;
  logic [mck_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: sv/mck_front.sv
// ----------------------------------------------------------------------------
// mck_front: character intake and timing
// Holds the configuration registers, looks the character up, works out the
// dit length with a bit-serial divider and pushes one entry to the queue.
// ----------------------------------------------------------------------------
module mck_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  mck_char_if.sink            char_i,
  mck_cfg_if.sink             cfg_i,
  input  mck_pkg::q_stat_t    q_stat_i,
  output logic                push_o,
  output mck_pkg::entry_t     push_data_o
);

  typedef enum logic [1:0] {FrIdle, FrDiv, FrPush} fr_state_e;

  fr_state_e                          state_q;
  logic [mck_pkg::WpmW-1:0]           wpm_q;
  logic [mck_pkg::WeightW-1:0]        weight_q;
  logic                               prev_space_q;
  logic [7:0]                         code_q;
  logic [mck_pkg::SpaceW-1:0]         space_q;
  logic                               is_space_q;
  logic                               ent_prev_q;
  logic [mck_pkg::WeightW-1:0]        div_q;
  logic [mck_pkg::WeightW-1:0]        rem_q;
  logic [mck_pkg::DurW-1:0]           num_q;
  logic [mck_pkg::DivCntW-1:0]        cnt_q;

  logic                               char_beat;
  logic [mck_pkg::SpaceW-1:0]         space_lu;
  logic [7:0]                         code_lu;
  logic [7:0]                         tbl_off;
  logic                               in_range;
  logic [mck_pkg::WeightW-1:0]        div_lu;
  logic [mck_pkg::WeightW:0]          trial;
  logic                               trial_ge;
  logic [mck_pkg::WeightW:0]          trial_sub;
  logic [mck_pkg::DurW:0]             dash_sum;
  logic [mck_pkg::DurW-1:0]           dash;

  assign char_i.ready = (state_q == FrIdle);
  assign cfg_i.ready  = 1'b1;
  assign char_beat    = char_i.valid && (state_q == FrIdle);

  // character classification and table lookups
  assign space_lu = mck_pkg::SpaceTable[wpm_q];
  assign in_range = (char_i.character >= mck_pkg::CharFirst) &&
                    (char_i.character <= mck_pkg::CharLast);
  assign tbl_off  = char_i.character - mck_pkg::CharFirst;
  assign code_lu  = in_range ? mck_pkg::CodeTable[tbl_off[6:0]] : mck_pkg::CodeEmpty;
  assign div_lu   = (weight_q < mck_pkg::WeightMin) ? 7'd1 : (weight_q - mck_pkg::WeightBias);

  // one restoring divider step
  assign trial     = {rem_q, num_q[mck_pkg::DurW-1]};
  assign trial_ge  = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  // dash is dit plus two unit spaces, saturated
  assign dash_sum = {1'b0, num_q} + {5'b0, space_q, 1'b0};
  assign dash     = dash_sum[mck_pkg::DurW] ? mck_pkg::DurMax : dash_sum[mck_pkg::DurW-1:0];

  assign push_o = (state_q == FrPush) && !q_stat_i.full;
  always_comb begin
    push_data_o.code       = code_q;
    push_data_o.space      = space_q;
    push_data_o.dit        = num_q;
    push_data_o.dash       = dash;
    push_data_o.is_space   = is_space_q;
    push_data_o.prev_space = ent_prev_q;
  end

  // state, configuration and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FrIdle;
      wpm_q        <= mck_pkg::WpmReset;
      weight_q     <= mck_pkg::WeightReset;
      prev_space_q <= 1'b0;
      code_q       <= '0;
      space_q      <= '0;
      is_space_q   <= 1'b0;
      ent_prev_q   <= 1'b0;
      div_q        <= '0;
      rem_q        <= '0;
      num_q        <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.reg_index)
          mck_pkg::CfgIdxWpm:    wpm_q    <= cfg_i.wdata[mck_pkg::WpmW-1:0];
          mck_pkg::CfgIdxWeight: weight_q <= cfg_i.wdata[mck_pkg::WeightW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        FrIdle: begin
          if (char_beat) begin
            code_q       <= code_lu;
            space_q      <= space_lu;
            is_space_q   <= (char_i.character == mck_pkg::CharSpace);
            ent_prev_q   <= prev_space_q;
            prev_space_q <= (char_i.character == mck_pkg::CharSpace);
            div_q        <= div_lu;
            rem_q        <= '0;
            num_q        <= {space_lu, 5'b0};
            cnt_q        <= mck_pkg::DivCntW'(mck_pkg::DivSteps - 1);
            state_q      <= FrDiv;
          end
        end
        FrDiv: begin
          rem_q <= trial_ge ? trial_sub[mck_pkg::WeightW-1:0] : trial[mck_pkg::WeightW-1:0];
          num_q <= {num_q[mck_pkg::DurW-2:0], trial_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= FrPush;
          end
        end
        FrPush: begin
          if (!q_stat_i.full) begin
            state_q <= FrIdle;
          end
        end
        default: state_q <= FrIdle;
      endcase
    end
  end

endmodule

FILE: sv/mck_queue.sv
// ----------------------------------------------------------------------------
// mck_queue: two-entry queue between front and back
// Register-based first-in first-out store of classified characters.
// ----------------------------------------------------------------------------
module mck_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mck_pkg::entry_t   push_data_i,
  input  logic              pop_i,
  output mck_pkg::entry_t   pop_data_o,
  output mck_pkg::q_stat_t  stat_o
);

  mck_pkg::entry_t  slot_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign pop_data_o   = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: sv/mck_back.sv
// ----------------------------------------------------------------------------
// mck_back: segment sequencer
// Takes one entry from the queue and walks its code, one key segment per
// beat, into a registered output stage.
// ----------------------------------------------------------------------------
module mck_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mck_pkg::q_stat_t  q_stat_i,
  input  mck_pkg::entry_t   pop_data_i,
  output logic              pop_o,
  mck_seg_if.source         seg_o
);

  typedef enum logic [2:0] {BkIdle, BkWord, BkMark, BkGap, BkEnd} bk_state_e;

  bk_state_e                   state_q;
  mck_pkg::entry_t             ent_q;
  logic                        valid_q;
  logic                        key_q;
  logic [mck_pkg::DurW-1:0]    dur_q;
  logic                        last_q;

  logic                        load;
  logic                        emit;
  logic [mck_pkg::DurW-1:0]    dur_space;
  logic [mck_pkg::DurW-1:0]    dur_letter;
  logic [mck_pkg::DurW-1:0]    dur_word;

  assign seg_o.valid        = valid_q;
  assign seg_o.key_down     = key_q;
  assign seg_o.duration_ms  = dur_q;
  assign seg_o.last_segment = last_q;

  assign load  = !valid_q || seg_o.ready;
  assign pop_o = (state_q == BkIdle) && !q_stat_i.empty;

  // a new segment enters the output stage
  assign emit  = load && ((state_q == BkWord) || (state_q == BkMark) ||
                          (state_q == BkGap) || (state_q == BkEnd));

  // gap lengths in unit spaces: one, two, and four or seven
  assign dur_space  = {5'b0, ent_q.space};
  assign dur_letter = {4'b0, ent_q.space, 1'b0};
  assign dur_word   = ent_q.prev_space ?
                      ({2'b0, ent_q.space, 3'b0} - {5'b0, ent_q.space}) :
                      {3'b0, ent_q.space, 2'b0};

  // sequencer and output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ent_q   <= '0;
      valid_q <= 1'b0;
      key_q   <= 1'b0;
      dur_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      if (emit) begin
        valid_q <= 1'b1;
      end else if (valid_q && seg_o.ready) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        BkIdle: begin
          if (!q_stat_i.empty) begin
            ent_q <= pop_data_i;
            if (pop_data_i.is_space) begin
              state_q <= BkWord;
            end else if (pop_data_i.code[7:1] != '0) begin
              state_q <= BkMark;
            end else begin
              state_q <= BkEnd;
            end
          end
        end
        BkWord: begin
          if (load) begin
            key_q   <= 1'b0;
            dur_q   <= dur_word;
            last_q  <= 1'b1;
            state_q <= BkIdle;
          end
        end
        BkMark: begin
          if (load) begin
            key_q   <= 1'b1;
            dur_q   <= ent_q.code[0] ? ent_q.dash : ent_q.dit;
            last_q  <= 1'b0;
            state_q <= BkGap;
          end
        end
        BkGap: begin
          if (load) begin
            key_q      <= 1'b0;
            dur_q      <= dur_space;
            last_q     <= 1'b0;
            ent_q.code <= {1'b0, ent_q.code[7:1]};
            state_q    <= (ent_q.code[7:2] != '0) ? BkMark : BkEnd;
          end
        end
        BkEnd: begin
          if (load) begin
            key_q   <= 1'b0;
            dur_q   <= dur_letter;
            last_q  <= 1'b1;
            state_q <= BkIdle;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

FILE: sv/morse_code_keyer.sv
// ----------------------------------------------------------------------------
// morse_code_keyer: ASCII character to key segment converter
// Turns each character into a run of key-down and key-up segments with
// their lengths in milliseconds.
// ----------------------------------------------------------------------------
// Usage:
//   char_i takes one ASCII character per beat; seg_o gives one segment per
//   beat (key state, length in ms, last-of-character flag); cfg_i writes the
//   speed (index 0) and weight (index 1) registers and is always ready.
//   The front part takes a character, looks it up and runs a 13-step
//   bit-serial divider for the dit length, then queues the entry; it takes
//   no new character until that entry is pushed into the two-entry queue.
//   The back part sends one segment per cycle from its output register
//   while seg_o is ready; for short runs the divider sets the sustained
//   character rate.
//   A stalled seg_o holds its segment; the front keeps taking characters
//   until the queue fills, then drops char_i.ready.
//   Reset empties the queue, sets speed 20 and weight 48 and clears the
//   record of a preceding word space.
// ----------------------------------------------------------------------------
module morse_code_keyer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mck_char_if.sink    char_i,
  mck_cfg_if.sink     cfg_i,
  mck_seg_if.source   seg_o
);

  logic               push;
  logic               pop;
  mck_pkg::entry_t    push_data;
  mck_pkg::entry_t    pop_data;
  mck_pkg::q_stat_t   q_stat;

  // intake, configuration and timing
  mck_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .cfg_i       (cfg_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  mck_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // segment sequencer
  mck_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .seg_o      (seg_o)
  );

endmodule
